/* hw/rtl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Shared constants, codes and types of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W     = 64;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
   } mem_wr_type;

endpackage

/* hw/rtl/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Binary max-heap of signed 64-bit values held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: each req_ item carries a mode (push, pop, peek) and a value. Every
// item yields exactly one rsp_ item with data, status, count and is_empty.
// A push writes the value after the last entry and sifts it up; each level
// has the steps read parent, then compare and write. A pop returns the root,
// moves the last entry to the root and sifts it down; each level has the
// steps read left child, read right child, then compare and write. A peek
// reads the root. The RAM's single read port makes the steps of a level
// run one after another. One item is worked on at a time.
// After reset the heap is empty; no clearing pass is needed. The result sits
// in an output register; while the receiver stalls, a new item is taken
// and worked on, but its result waits until the previous one is taken.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
   import mhpq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_data,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_is_empty
);

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_ROOT_RD, S_ROOT_GET,
      S_LAST_GET, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DONE
   } state_type;

   state_type                 state_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [ADDR_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0]  cur_ff;
   logic signed [DATA_W-1:0]  left_ff;
   logic [MODE_W-1:0]         mode_ff;
   logic signed [DATA_W-1:0]  res_data_ff;
   logic [STATUS_W-1:0]       res_status_ff;
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_data_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   mem_wr_type                wr;
   logic [ADDR_W-1:0]         rd_addr;
   logic [DATA_W-1:0]         rd_data;
   logic signed [DATA_W-1:0]  rd_val;

   logic [ADDR_W-1:0]         parent;
   logic [COUNT_W:0]          lchild;
   logic [COUNT_W:0]          rchild;
   logic                      l_ok;
   logic                      r_ok;

   assign rd_val = rd_data;
   assign parent = ADDR_W'((pos_ff - 1'b1) >> 1);
   assign lchild = {pos_ff, 1'b1} + (COUNT_W + 1)'(0);
   assign rchild = lchild + 1'b1;
   assign l_ok   = lchild < (COUNT_W + 1)'(count_ff);
   assign r_ok   = rchild < (COUNT_W + 1)'(count_ff);

   mhpq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      rd_addr = '0;
      case (state_ff)
         S_UP_RD:    rd_addr = parent;
         S_ROOT_RD:  rd_addr = '0;
         S_ROOT_GET: rd_addr = ADDR_W'(count_ff - 1'b1);
         S_DN_RDL:   rd_addr = lchild[ADDR_W-1:0];
         S_DN_RDR:   rd_addr = rchild[ADDR_W-1:0];
         default:    rd_addr = '0;
      endcase
   end

   // Combinational write decisions for the states that write the RAM.
   logic                      up_swap;
   logic                      dn_l;
   logic                      dn_r;
   logic signed [DATA_W-1:0]  best;
   always_comb begin
      up_swap = (state_ff == S_UP_CMP) && (pos_ff != '0) && (rd_val < cur_ff);
      dn_l    = l_ok && (left_ff > cur_ff);
      best    = dn_l ? left_ff : cur_ff;
      dn_r    = r_ok && (rd_val > best);
      wr      = '0;
      case (state_ff)
         S_IDLE: begin
            wr.en   = req_valid && (req_mode == MODE_PUSH) &&
                      (count_ff < COUNT_W'(CAPACITY));
            wr.addr = count_ff[ADDR_W-1:0];
            wr.data = req_value;
         end
         S_UP_CMP: begin
            wr.en   = 1'b1;
            wr.addr = pos_ff;
            wr.data = up_swap ? rd_val : cur_ff;
         end
         S_LAST_GET: begin
            wr.en   = 1'b1;
            wr.addr = '0;
            wr.data = rd_val;
         end
         S_DN_CMP: begin
            wr.en   = 1'b1;
            wr.addr = pos_ff;
            wr.data = dn_r ? rd_val : best;
         end
         default: wr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff       <= req_mode;
                  res_data_ff   <= '0;
                  cur_ff        <= req_value;
                  pos_ff        <= count_ff[ADDR_W-1:0];
                  if (req_mode == MODE_PUSH) begin
                     if (count_ff >= COUNT_W'(CAPACITY)) begin
                        res_status_ff <= STATUS_FULL;
                        state_ff      <= S_DONE;
                     end else begin
                        res_status_ff <= STATUS_OK;
                        count_ff      <= count_ff + 1'b1;
                        state_ff      <= (count_ff == '0) ? S_DONE : S_UP_RD;
                     end
                  end else if (req_mode == MODE_POP || req_mode == MODE_PEEK) begin
                     if (count_ff == '0) begin
                        res_status_ff <= STATUS_EMPTY;
                        state_ff      <= S_DONE;
                     end else begin
                        res_status_ff <= STATUS_OK;
                        state_ff      <= S_ROOT_RD;
                     end
                  end else begin
                     res_status_ff <= STATUS_OK;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_UP_RD: state_ff <= S_UP_CMP;
            S_UP_CMP: begin
               if (up_swap && parent != '0) begin
                  pos_ff   <= parent;
                  state_ff <= S_UP_RD;
               end else if (up_swap) begin
                  pos_ff   <= parent;
                  state_ff <= S_UP_CMP;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_ROOT_RD: state_ff <= S_ROOT_GET;
            S_ROOT_GET: begin
               res_data_ff <= rd_val;
               if (mode_ff == MODE_POP) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= (count_ff == COUNT_W'(1)) ? S_DONE : S_LAST_GET;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_LAST_GET: begin
               cur_ff   <= rd_val;
               pos_ff   <= '0;
               state_ff <= S_DN_RDL;
            end
            S_DN_RDL: state_ff <= l_ok ? S_DN_RDR : S_DN_CMP;
            S_DN_RDR: begin
               left_ff  <= rd_val;
               state_ff <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (dn_l || dn_r) begin
                  pos_ff   <= dn_r ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];
                  state_ff <= S_DN_RDL;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= res_data_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = (rsp_count_ff == '0);

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count beyond capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted item left no work");
   a_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_is_empty && rsp_data == '0)
      else $error("empty result carries data");
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == COUNT_W'(CAPACITY))
      else $error("full status with room left");
`endif

endmodule

/* hw/rtl/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
